// ===== design/assert_macros.svh =====
// Assertion macros shared by the tag ECC check and correct design.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset check failed");

`endif

// ===== design/oobecc_pkg.sv =====
// Package for the OOB tag ECC check and correct design.
// Holds the request and result types, status codes and tag layout constants.
`timescale 1ns / 1ps

package oobecc_pkg;

  // Tag word layout.
  localparam int TAG_W    = 64;
  localparam int SPARE_W  = 64;
  localparam int ECC_LSB  = 50;
  localparam int ECC_W    = 12;
  localparam int ECC_MSB  = ECC_LSB + ECC_W - 1;
  localparam int CODE_W   = 7;
  localparam int BITIDX_W = 6;

  // Check outcome codes.
  typedef enum logic [1:0] {
    ST_CLEAN     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_UNCORR    = 2'd2
  } status_t;

  // One request: the 16-byte spare area as two words.
  typedef struct packed {
    logic [SPARE_W-1:0] spare_low;
    logic [SPARE_W-1:0] spare_high;
  } in_t;

  // One result.
  typedef struct packed {
    status_t            status;
    logic [TAG_W-1:0]   tag_word;
    logic               image_ok;
  } out_t;

endpackage

// ===== design/oobecc_code.sv =====
// Parity code of a tag word: XOR of the 1-based positions of all set bits,
// with the ECC field left out. Depends on oobecc_pkg.
`timescale 1ns / 1ps

module oobecc_code (
  input  logic [oobecc_pkg::TAG_W-1:0]  word,
  output logic [oobecc_pkg::CODE_W-1:0] code
);

  // Bit j of the code covers every tag position whose 1-based index has bit j set.
  function automatic logic [oobecc_pkg::TAG_W-1:0] code_mask(input int j);
    logic [oobecc_pkg::TAG_W-1:0] m;
    m = '0;
    for (int p = 0; p < oobecc_pkg::TAG_W; p++) begin
      if ((((p + 1) >> j) & 1) != 0 &&
          !(p >= oobecc_pkg::ECC_LSB && p <= oobecc_pkg::ECC_MSB)) begin
        m[p] = 1'b1;
      end
    end
    return m;
  endfunction

  // One XOR reduction tree per code bit.
  for (genvar j = 0; j < oobecc_pkg::CODE_W; j++) begin : g_bit
    localparam logic [oobecc_pkg::TAG_W-1:0] MASK = code_mask(j);
    assign code[j] = ^(word & MASK);
  end

endmodule

// ===== design/oobecc_correct.sv =====
// Gathers the tag word from the spare area, checks its ECC and corrects one bit.
// Depends on oobecc_pkg and oobecc_code.
`timescale 1ns / 1ps

module oobecc_correct (
  input  oobecc_pkg::in_t  req,
  output oobecc_pkg::out_t res
);

  logic [oobecc_pkg::TAG_W-1:0]    word;
  logic [oobecc_pkg::CODE_W-1:0]   code;
  logic [oobecc_pkg::ECC_W-1:0]    stored;
  logic [oobecc_pkg::ECC_W-1:0]    syn;
  logic [oobecc_pkg::ECC_W-1:0]    syn_m1;
  logic [oobecc_pkg::BITIDX_W-1:0] flip_idx;
  logic [oobecc_pkg::TAG_W-1:0]    flipped;
  logic [oobecc_pkg::CODE_W-1:0]   new_code;
  logic                            in_field;

  // Gather spare bytes 0..3, 6..7 and 11..12 into the tag word.
  assign word = {req.spare_high[39:24], req.spare_low[63:48], req.spare_low[31:0]};

  oobecc_code u_code (
    .word (word),
    .code (code)
  );

  // Syndrome against the stored field.
  assign stored   = word[oobecc_pkg::ECC_MSB:oobecc_pkg::ECC_LSB];
  assign syn      = stored ^ {{(oobecc_pkg::ECC_W - oobecc_pkg::CODE_W){1'b0}}, code};
  assign syn_m1   = syn - oobecc_pkg::ECC_W'(1);
  assign flip_idx = syn_m1[oobecc_pkg::BITIDX_W-1:0];
  assign flipped  = word ^ (oobecc_pkg::TAG_W'(1) << flip_idx);

  // A flip inside the ECC field leaves the covered bits, and so the code, unchanged.
  assign in_field = (syn >= oobecc_pkg::ECC_W'(oobecc_pkg::ECC_LSB + 1)) &&
                    (syn <= oobecc_pkg::ECC_W'(oobecc_pkg::ECC_MSB + 1));
  assign new_code = in_field ? code : (code ^ syn[oobecc_pkg::CODE_W-1:0]);

  // Pick the outcome and rebuild the ECC field.
  always_comb begin
    if (syn == '0) begin
      res.status   = oobecc_pkg::ST_CLEAN;
      res.tag_word = word;
      res.image_ok = 1'b1;
    end else if (syn <= oobecc_pkg::ECC_W'(oobecc_pkg::TAG_W)) begin
      res.status   = oobecc_pkg::ST_CORRECTED;
      res.tag_word = {flipped[oobecc_pkg::TAG_W-1:oobecc_pkg::ECC_MSB+1],
                      (oobecc_pkg::ECC_W)'(new_code),
                      flipped[oobecc_pkg::ECC_LSB-1:0]};
      res.image_ok = 1'b1;
    end else begin
      res.status   = oobecc_pkg::ST_UNCORR;
      res.tag_word = {word[oobecc_pkg::TAG_W-1:oobecc_pkg::ECC_MSB+1],
                      (oobecc_pkg::ECC_W)'(code),
                      word[oobecc_pkg::ECC_LSB-1:0]};
      res.image_ok = 1'b0;
    end
  end

endmodule

// ===== design/oob_tag_ecc_check_correct_core.sv =====
// A request is held in the input register and its result then in the result register.
// Throughput: one request per cycle unless out_ready stalls; an input register and a
// result register bound a single pass through gather, XOR tree and correction logic.
// Reset (synchronous, active high) empties both registers; no other state exists.
// Depends on oobecc_pkg, oobecc_correct and assert_macros.svh.
`timescale 1ns / 1ps

module oob_tag_ecc_check_correct_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  oobecc_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output oobecc_pkg::out_t out_data
);

  logic             s1_valid;
  oobecc_pkg::in_t  s1_data;
  oobecc_pkg::out_t res;
  logic             out_adv;

  // The result register moves when empty or taken; the input register follows it.
  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  oobecc_correct u_correct (
    .req (s1_data),
    .res (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      out_data <= res;
    end
  end

`include "assert_macros.svh"

  // A held request stays put while the result register is stalled.
  `ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !out_adv, s1_valid && $stable(s1_data))

  // The image flag agrees with the status of each result.
  `ASSERT_IMPLY(a_ok_status, clk, rst, out_valid,
                out_data.image_ok == (out_data.status != oobecc_pkg::ST_UNCORR))

  // A stalled result is not overwritten.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // Reset leaves no result pending.
  `ASSERT_NEXT_ALWAYS(a_rst_empty, clk, rst, !out_valid && !s1_valid)

endmodule
